/* hdl/lru_pkg.sv */
// Package for the LRU page replacement block: sizes, the frame memory entry,
// the memory write bundle, the sequencer states and the result record.
// No dependencies; used by lru_frame_ram, lru_engine and lru_page_replacement.
package lru_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_BITS   = $clog2(FRAMES + 1);
  localparam int RANK_BITS  = IDX_BITS;
  localparam int LIM_BITS   = RANK_BITS + 1;
  localparam int CFG_BITS   = 4;
  localparam int FRAME_OUT_BITS = 3;
  localparam int FAULT_BITS = 16;

  localparam logic [FAULT_BITS-1:0] FAULT_MAX = {FAULT_BITS{1'b1}};
  localparam logic [RANK_BITS-1:0]  RANK_MAX  = RANK_BITS'(FRAMES - 1);
  localparam logic [CFG_BITS-1:0]   FRAMES_IN_USE_RESET = CFG_BITS'(4);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [RANK_BITS-1:0] rank;
  } lru_entry_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    lru_entry_t          data;
  } lru_ram_wr_t;

  typedef struct packed {
    logic                      hit;
    logic [FRAME_OUT_BITS-1:0] frame;
    logic [FAULT_BITS-1:0]     faults;
    logic                      last;
  } lru_result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } lru_state_t;

endpackage

/* hdl/lru_frame_ram.sv */
// Frame memory: one page number and one recency rank per frame.
// One write port and one registered read port. Depends on lru_pkg.
module lru_frame_ram (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [lru_pkg::IDX_BITS-1:0] rd_addr,
  output lru_pkg::lru_entry_t          rd_data,
  input  lru_pkg::lru_ram_wr_t         wr
);

  lru_pkg::lru_entry_t mem [lru_pkg::FRAMES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/lru_engine.sv */
// Replacement sequencer: a search pass and an aging pass over the frame memory
// per reference, plus the valid bits and the fault counter.
// Depends on lru_pkg and lru_frame_ram.
module lru_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lru_pkg::CNT_BITS-1:0]   frames_used,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lru_pkg::PAGE_BITS-1:0]  in_page,
  input  logic                           in_last,
  output logic                           res_valid,
  input  logic                           res_ready,
  output lru_pkg::lru_result_t           res
);

  lru_pkg::lru_state_t state, state_next;

  logic [lru_pkg::CNT_BITS-1:0]  addr;
  logic [lru_pkg::CNT_BITS-1:0]  m;
  logic [lru_pkg::CNT_BITS-1:0]  last_idx;
  logic                          rd_en;
  logic                          rvalid;
  logic [lru_pkg::IDX_BITS-1:0]  idx_q;
  lru_pkg::lru_entry_t           rd_data;
  lru_pkg::lru_ram_wr_t          wr;

  logic [lru_pkg::PAGE_BITS-1:0] page;
  logic                          last;
  logic                          hit_found;
  logic [lru_pkg::IDX_BITS-1:0]  hit_f;
  logic [lru_pkg::RANK_BITS-1:0] hit_rank;
  logic                          empty_found;
  logic [lru_pkg::IDX_BITS-1:0]  empty_f;
  logic [lru_pkg::IDX_BITS-1:0]  old_f;
  logic [lru_pkg::RANK_BITS-1:0] oldest;
  logic [lru_pkg::FRAMES-1:0]    valid;
  logic [lru_pkg::FAULT_BITS-1:0] faults;
  logic [lru_pkg::FAULT_BITS-1:0] faults_new;

  logic                          at_last;
  logic                          scan_end;
  logic                          upd_end;
  logic                          cur_valid;
  logic [lru_pkg::IDX_BITS-1:0]  f_sel;
  logic [lru_pkg::LIM_BITS-1:0]  limit;

  lru_frame_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr[lru_pkg::IDX_BITS-1:0]),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign last_idx  = m - lru_pkg::CNT_BITS'(1);
  assign at_last   = rvalid && (lru_pkg::CNT_BITS'(idx_q) == last_idx);
  assign scan_end  = (state == lru_pkg::S_SCAN) && at_last;
  assign upd_end   = (state == lru_pkg::S_UPDATE) && at_last;
  assign cur_valid = valid[idx_q];

  // Frame chosen by the search pass and the age limit for the other frames.
  always_comb begin
    if (hit_found) begin
      f_sel = hit_f;
      limit = lru_pkg::LIM_BITS'(hit_rank);
    end else if (empty_found) begin
      f_sel = empty_f;
      limit = lru_pkg::LIM_BITS'(lru_pkg::FRAMES);
    end else begin
      f_sel = old_f;
      limit = lru_pkg::LIM_BITS'(oldest);
    end
  end

  assign faults_new = (hit_found || faults == lru_pkg::FAULT_MAX) ? faults
                                                                  : faults + 1'b1;

  // Write-back during the aging pass: the chosen frame becomes newest, and
  // valid frames younger than the limit grow one step older.
  always_comb begin
    wr.en        = 1'b0;
    wr.addr      = idx_q;
    wr.data.page = rd_data.page;
    wr.data.rank = rd_data.rank + 1'b1;
    if (rvalid && state == lru_pkg::S_UPDATE) begin
      if (idx_q == f_sel) begin
        wr.en        = 1'b1;
        wr.data.page = page;
        wr.data.rank = '0;
      end else if (cur_valid && (lru_pkg::LIM_BITS'(rd_data.rank) < limit) &&
                   (rd_data.rank != lru_pkg::RANK_MAX)) begin
        wr.en = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lru_pkg::S_IDLE: begin
        if (in_valid) state_next = lru_pkg::S_SCAN;
      end
      lru_pkg::S_SCAN: begin
        if (scan_end) state_next = lru_pkg::S_UPDATE;
      end
      lru_pkg::S_UPDATE: begin
        if (upd_end) state_next = lru_pkg::S_DONE;
      end
      lru_pkg::S_DONE: begin
        if (res_ready) state_next = lru_pkg::S_IDLE;
      end
      default: state_next = lru_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    case (state)
      lru_pkg::S_IDLE:   in_ready  = 1'b1;
      lru_pkg::S_SCAN:   rd_en     = (addr < m);
      lru_pkg::S_UPDATE: rd_en     = (addr < m);
      lru_pkg::S_DONE:   res_valid = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lru_pkg::S_IDLE;
      rvalid <= 1'b0;
      addr   <= '0;
      valid  <= '0;
      faults <= '0;
    end else begin
      state  <= state_next;
      rvalid <= rd_en;
      if (in_valid && in_ready) begin
        addr <= '0;
      end else if (scan_end) begin
        addr <= '0;
      end else if (rd_en) begin
        addr <= addr + 1'b1;
      end
      // The end of a string empties every frame and restarts the count.
      if (upd_end && last) begin
        valid  <= '0;
        faults <= '0;
      end else begin
        if (wr.en && idx_q == f_sel) begin
          valid[f_sel] <= 1'b1;
        end
        if (upd_end) begin
          faults <= faults_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx_q <= addr[lru_pkg::IDX_BITS-1:0];
    end
    if (in_valid && in_ready) begin
      page        <= in_page;
      last        <= in_last;
      m           <= frames_used;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end
    if (rvalid && state == lru_pkg::S_SCAN) begin
      if (cur_valid && rd_data.page == page && !hit_found) begin
        hit_found <= 1'b1;
        hit_f     <= idx_q;
        hit_rank  <= rd_data.rank;
      end
      if (!cur_valid && !empty_found) begin
        empty_found <= 1'b1;
        empty_f     <= idx_q;
      end
      if (idx_q == '0 || rd_data.rank > oldest) begin
        old_f  <= idx_q;
        oldest <= rd_data.rank;
      end
    end
    if (upd_end) begin
      res.hit    <= hit_found;
      res.frame  <= lru_pkg::FRAME_OUT_BITS'(f_sel);
      res.faults <= faults_new;
      res.last   <= last;
    end
  end

endmodule

/* hdl/lru_page_replacement.sv */
// Top level of the LRU page replacement block: configuration register,
// output register and the replacement sequencer. Depends on lru_pkg and lru_engine.
//
// Usage. Each beat on the s_axis channel is one page reference: tdata carries
// the page number and tlast marks the final reference of a string. Each
// reference yields exactly one beat on the m_axis channel: tuser is the hit
// flag, tdata the frame that was hit or filled and the running fault total,
// and tlast echoes the end-of-string mark. After a result with tlast set, all
// frames are empty and the fault total is back to zero.
// The user writes frames_in_use through cfg_wr_en / cfg_wr_data while no reference is
// in flight, not enforced by the block; zero acts as one frame, above eight as eight.
// Timing. With m frames in use, a reference runs from accept to the next accept
// through one search pass and one aging pass over the m frames in the frame
// memory, one frame per cycle over its single read port, plus an accept state
// and a handoff state. The sequencer registers the result as the aging pass
// ends and passes it on to the output register. When the receiver stalls, the
// result waits in the output register and the block still accepts and processes
// the next reference; it then holds that one until the output register frees up.
// Reset clears every valid bit and the fault counter at once (no clearing
// pass) and sets frames_in_use to four.
module lru_page_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] page_number
  input  logic        s_axis_tlast,   // last_reference
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] frame_index, [18:3] fault_count, rest zero
  output logic [0:0]  m_axis_tuser,   // [0] hit
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data     // frames_in_use
);

  logic [lru_pkg::CFG_BITS-1:0] frames_in_use;
  logic [lru_pkg::CNT_BITS-1:0] frames_used;
  logic                         eng_res_valid;
  logic                         eng_res_ready;
  lru_pkg::lru_result_t         eng_res;
  lru_pkg::lru_result_t         out_res;
  logic                         out_valid;

  // The configuration register takes every write; the clamp is applied here.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      frames_used = lru_pkg::CNT_BITS'(1);
    end else if (int'(frames_in_use) > lru_pkg::FRAMES) begin
      frames_used = lru_pkg::CNT_BITS'(lru_pkg::FRAMES);
    end else begin
      frames_used = lru_pkg::CNT_BITS'(frames_in_use);
    end
  end

  lru_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .frames_used (frames_used),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_page     (s_axis_tdata[lru_pkg::PAGE_BITS-1:0]),
    .in_last     (s_axis_tlast),
    .res_valid   (eng_res_valid),
    .res_ready   (eng_res_ready),
    .res         (eng_res)
  );

  // Output register: loads whenever it is empty or its beat is being taken.
  assign eng_res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_res_ready) begin
      out_valid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      out_res <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_res.faults, out_res.frame};
  assign m_axis_tuser  = out_res.hit;
  assign m_axis_tlast  = out_res.last;

  // A reference is taken only when the sequencer is free, so ready drops
  // right after every accepted beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("reference accepted while the previous one is in flight");

  // Every page fault counts itself, so a fault result never shows a zero total.
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[18:3] != 16'd0)
    else $error("page fault reported with a zero fault total");

  // The sequencer holds its result until the output register can take it.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    eng_res_valid && !eng_res_ready |=> eng_res_valid && $stable(eng_res))
    else $error("sequencer result dropped or changed while stalled");

endmodule
